/* src/mfdd_pkg.sv */
// Shared types and protocol constants for the frame deframer and action decoder.
package mfdd_pkg;

    // Decoded action codes
    typedef enum logic [3:0] {
        ACT_NONE      = 4'd0,
        ACT_MOTOR_H   = 4'd1,
        ACT_MOTOR_V   = 4'd2,
        ACT_SYRINGE1  = 4'd3,
        ACT_SYRINGE2  = 4'd4,
        ACT_WASTE     = 4'd5,
        ACT_DILUENT   = 4'd6,
        ACT_LYSE      = 4'd7,
        ACT_HGB_LED   = 4'd8,
        ACT_HGB_BK    = 4'd9,
        ACT_HGB_REF   = 4'd10,
        ACT_WBC_CONST = 4'd11,
        ACT_WBC_BURN  = 4'd12,
        ACT_RBC_BURN  = 4'd13,
        ACT_START     = 4'd14,
        ACT_STOP      = 4'd15
    } t_action;

    // Frame positions of the stored bytes
    localparam logic [8:0] POS_CONTROL = 9'd1;
    localparam logic [8:0] POS_LENGTH  = 9'd2;
    localparam logic [8:0] POS_B3      = 9'd3;
    localparam logic [8:0] POS_B4      = 9'd4;
    localparam logic [8:0] POS_B5      = 9'd5;
    localparam logic [8:0] POS_B6      = 9'd6;

    // Bytes in a frame besides the payload
    localparam logic [8:0] FRAME_OVERHEAD = 9'd5;

    // Control codes
    localparam logic [7:0] CTRL_MOTOR    = 8'h40;
    localparam logic [7:0] CTRL_FLUID    = 8'hA9;
    localparam logic [7:0] CTRL_ANALYZER = 8'hB6;
    localparam logic [7:0] ANALYZER_SUB  = 8'h61;

    // Motor and syringe selectors
    localparam logic [7:0] SEL_MOTOR   = 8'h02;
    localparam logic [7:0] SEL_SYRINGE = 8'h03;
    localparam logic [7:0] UNIT_MASK   = 8'hF0;
    localparam logic [7:0] UNIT_FIRST  = 8'h00;
    localparam logic [7:0] UNIT_SECOND = 8'h20;

    // Fluid fault selectors
    localparam logic [7:0] FLUID_WASTE   = 8'h03;
    localparam logic [7:0] FLUID_DILUENT = 8'h01;
    localparam logic [7:0] FLUID_LYSE    = 8'h00;
    localparam logic [7:0] FAULT_SET     = 8'h01;

    // Analyzer commands
    localparam logic [7:0] CMD_HGB_LED   = 8'h10;
    localparam logic [7:0] CMD_HGB_BK    = 8'h18;
    localparam logic [7:0] CMD_HGB_REF   = 8'h19;
    localparam logic [7:0] CMD_WBC_CONST = 8'h15;
    localparam logic [7:0] CMD_WBC_BURN  = 8'h11;
    localparam logic [7:0] CMD_RBC_BURN  = 8'h12;
    localparam logic [7:0] CMD_START     = 8'h16;
    localparam logic [7:0] CMD_STOP      = 8'h1A;

    // Stored frame bytes handed to the decoder
    typedef struct packed {
        logic [7:0] control;
        logic [7:0] b3;
        logic [7:0] b4;
        logic [7:0] b5;
        logic [7:0] b6;
    } t_frame_bytes;

endpackage

/* src/mcu_frame_deframe_dispatch_top.sv */
// Top level of the receive deframer: byte counting, frame storage and result register.
// A received byte is first held in the input register; the byte that ends a frame is
// merged and decoded combinationally, and its result is held in the result register.
// Throughput: one received byte per cycle while the result register has room for a
// finished frame; the only loop is the byte-position counter and its frame-end compare.
// Reset: synchronous, active low; it empties both registers and clears the frame state.
module mcu_frame_deframe_dispatch_top
    import mfdd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Received byte channel
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_rx_byte,
    // Decoded frame channel
    output logic       o_valid,
    input  logic       i_ready,
    output logic [3:0] o_action,
    output logic [7:0] o_action_value,
    output logic [7:0] o_control_code,
    output logic [8:0] o_frame_length
);

    // Input register: holds one received byte until the frame logic takes it.
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    // Frame state. The position counts bytes of the current frame; byte 1 is the
    // control code, byte 2 the payload length and bytes 3 to 6 feed the decoder.
    // Bytes a short frame never carries stay at zero from the last clear.
    logic [8:0] r_pos;
    logic [7:0] r_len;
    logic [7:0] r_ctrl;
    logic [7:0] r_b3, r_b4, r_b5, r_b6;

    logic [7:0] n_len;
    logic [7:0] n_ctrl;
    logic [7:0] n_b3, n_b4, n_b5, n_b6;

    // Result register
    logic       r_out_valid;
    t_action    r_out_action;
    logic [7:0] r_out_value;
    logic [7:0] r_out_ctrl;
    logic [8:0] r_out_len;

    logic [8:0]   frame_total;
    logic         frame_done;
    logic         out_free;
    logic         advance;
    t_frame_bytes dec_frame;
    t_action      dec_action;
    logic [7:0]   dec_value;

    // Merge the byte in the input register into the stored bytes. The decode of the
    // final word must see the byte that arrives with it.
    always_comb begin
        n_ctrl = (r_pos == POS_CONTROL) ? r_in_byte : r_ctrl;
        n_len  = (r_pos == POS_LENGTH)  ? r_in_byte : r_len;
        n_b3   = (r_pos == POS_B3)      ? r_in_byte : r_b3;
        n_b4   = (r_pos == POS_B4)      ? r_in_byte : r_b4;
        n_b5   = (r_pos == POS_B5)      ? r_in_byte : r_b5;
        n_b6   = (r_pos == POS_B6)      ? r_in_byte : r_b6;
    end

    // A frame is 5 plus length bytes long. It never ends before byte 4, so a frame
    // with a short or not yet seen length still runs through byte 4.
    assign frame_total = FRAME_OVERHEAD + {1'b0, n_len};
    assign frame_done  = (r_pos >= POS_B4) && (r_pos >= frame_total - 9'd1);

    assign dec_frame = '{control: n_ctrl, b3: n_b3, b4: n_b4, b5: n_b5, b6: n_b6};

    mfdd_decode u_decode (
        .i_frame  (dec_frame),
        .o_action (dec_action),
        .o_value  (dec_value)
    );

    // A byte that ends a frame needs room in the result register; every other byte
    // only updates the frame state and always moves on.
    assign out_free = !r_out_valid || i_ready;
    assign advance  = r_in_valid && (!frame_done || out_free);
    assign o_ready  = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // Frame state: cleared at the end of every frame, ready for the next header.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= 9'd0;
            r_len  <= 8'd0;
            r_ctrl <= 8'd0;
            r_b3   <= 8'd0;
            r_b4   <= 8'd0;
            r_b5   <= 8'd0;
            r_b6   <= 8'd0;
        end else if (advance) begin
            if (frame_done) begin
                r_pos  <= 9'd0;
                r_len  <= 8'd0;
                r_ctrl <= 8'd0;
                r_b3   <= 8'd0;
                r_b4   <= 8'd0;
                r_b5   <= 8'd0;
                r_b6   <= 8'd0;
            end else begin
                r_pos  <= r_pos + 9'd1;
                r_len  <= n_len;
                r_ctrl <= n_ctrl;
                r_b3   <= n_b3;
                r_b4   <= n_b4;
                r_b5   <= n_b5;
                r_b6   <= n_b6;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && frame_done) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && frame_done) begin
            r_out_action <= dec_action;
            r_out_value  <= dec_value;
            r_out_ctrl   <= n_ctrl;
            r_out_len    <= frame_total;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_action       = r_out_action;
    assign o_action_value = r_out_value;
    assign o_control_code = r_out_ctrl;
    assign o_frame_length = r_out_len;

endmodule

/* src/mfdd_decode.sv */
// Combinational action decoder for a completed frame.
module mfdd_decode
    import mfdd_pkg::*;
(
    input  t_frame_bytes i_frame,
    output t_action      o_action,
    output logic [7:0]   o_value
);

    logic [7:0] unit_sel;
    logic [7:0] fault_flag;

    assign unit_sel   = i_frame.b6 & UNIT_MASK;
    assign fault_flag = (i_frame.b5 == FAULT_SET) ? 8'd1 : 8'd0;

    always_comb begin
        o_action = ACT_NONE;
        o_value  = 8'd0;
        if (i_frame.control == CTRL_MOTOR) begin
            if (i_frame.b5 == SEL_MOTOR) begin
                if (unit_sel == UNIT_FIRST) begin
                    o_action = ACT_MOTOR_H;
                end else if (unit_sel == UNIT_SECOND) begin
                    o_action = ACT_MOTOR_V;
                end
            end else if (i_frame.b5 == SEL_SYRINGE) begin
                if (unit_sel == UNIT_FIRST) begin
                    o_action = ACT_SYRINGE1;
                end else if (unit_sel == UNIT_SECOND) begin
                    o_action = ACT_SYRINGE2;
                end
            end
        end else if (i_frame.control == CTRL_FLUID) begin
            if (i_frame.b4 == FLUID_WASTE) begin
                o_action = ACT_WASTE;
                o_value  = fault_flag;
            end else if (i_frame.b4 == FLUID_DILUENT) begin
                o_action = ACT_DILUENT;
                o_value  = fault_flag;
            end else if (i_frame.b4 == FLUID_LYSE) begin
                o_action = ACT_LYSE;
                o_value  = fault_flag;
            end
        end else if (i_frame.control == CTRL_ANALYZER && i_frame.b3 == ANALYZER_SUB) begin
            unique case (i_frame.b4)
                CMD_HGB_LED: begin
                    o_action = ACT_HGB_LED;
                    o_value  = i_frame.b5;
                end
                CMD_HGB_BK:    o_action = ACT_HGB_BK;
                CMD_HGB_REF:   o_action = ACT_HGB_REF;
                CMD_WBC_CONST: begin
                    o_action = ACT_WBC_CONST;
                    o_value  = i_frame.b5;
                end
                CMD_WBC_BURN: begin
                    o_action = ACT_WBC_BURN;
                    o_value  = i_frame.b6;
                end
                CMD_RBC_BURN: begin
                    o_action = ACT_RBC_BURN;
                    o_value  = i_frame.b6;
                end
                CMD_START: begin
                    o_action = ACT_START;
                    o_value  = i_frame.b6;
                end
                CMD_STOP:      o_action = ACT_STOP;
                default:       o_action = ACT_NONE;
            endcase
        end
    end

endmodule
